/* rtl/double_ended_queue_assert.svh */
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DEQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque assertion failed");

// Next-cycle implication, checked outside reset.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque assertion failed");

`endif

/* rtl/deq_pkg.sv */
`default_nettype none
package deq_pkg;

   localparam int DepthDef  = 16;
   localparam int DataWidth = 32;
   localparam int FuncW     = 2;
   localparam int StatusW   = 2;
   localparam int CountW    = 5;

   localparam logic [FuncW-1:0] FUNC_INS_FRONT = 2'd0;
   localparam logic [FuncW-1:0] FUNC_INS_REAR  = 2'd1;
   localparam logic [FuncW-1:0] FUNC_REM_FRONT = 2'd2;
   localparam logic [FuncW-1:0] FUNC_REM_REAR  = 2'd3;

   localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
   localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [StatusW-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_SHIFT_R,
      CMD_PUSH_REAR,
      CMD_SHIFT_L,
      CMD_POP_REAR
   } cell_cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } ctl_state_type;

   typedef struct packed {
      logic                        valid;
      logic                        carry;
      logic signed [DataWidth-1:0] data;
      logic signed [DataWidth-1:0] carry_data;
   } cell_link_type;

   typedef struct packed {
      logic        [FuncW-1:0]     func;
      logic signed [DataWidth-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] removed_value;
      logic        [StatusW-1:0]   status;
      logic        [CountW-1:0]    count_after;
   } rsp_type;

endpackage
`default_nettype wire

/* rtl/deq_cell.sv */
`default_nettype none
module deq_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  deq_pkg::cell_cmd_type                 cmd,
   input  logic signed [deq_pkg::DataWidth-1:0]  value,
   input  deq_pkg::cell_link_type                left,
   input  deq_pkg::cell_link_type                right,
   output deq_pkg::cell_link_type                link
);

   logic                                 valid_ff, valid_in;
   logic                                 carry_ff, carry_in;
   logic signed [deq_pkg::DataWidth-1:0] data_ff, data_in;
   logic signed [deq_pkg::DataWidth-1:0] carry_data_ff, carry_data_in;

   // carry moves one cell towards the front every cycle
   always_comb begin
      valid_in      = valid_ff;
      data_in       = data_ff;
      carry_in      = right.carry;
      carry_data_in = right.carry_data;
      case (cmd)
         deq_pkg::CMD_HOLD: begin
         end
         deq_pkg::CMD_SHIFT_R: begin
            data_in  = left.data;
            valid_in = left.valid;
         end
         deq_pkg::CMD_PUSH_REAR: begin
            if (!valid_ff && left.valid) begin
               data_in  = value;
               valid_in = 1'b1;
            end
         end
         deq_pkg::CMD_SHIFT_L: begin
            data_in  = right.data;
            valid_in = right.valid;
         end
         deq_pkg::CMD_POP_REAR: begin
            if (valid_ff && !right.valid) begin
               valid_in      = 1'b0;
               carry_in      = 1'b1;
               carry_data_in = data_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         carry_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         carry_ff <= carry_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff       <= data_in;
      carry_data_ff <= carry_data_in;
   end

   assign link.valid      = valid_ff;
   assign link.carry      = carry_ff;
   assign link.data       = data_ff;
   assign link.carry_data = carry_data_ff;

endmodule
`default_nettype wire

/* rtl/double_ended_queue.sv */
// Bounded double-ended queue of signed 32-bit values, DEPTH entries.
// Request: start with req_data (func, value); taken on a clock edge with start
// high and busy low. Func selects insert front, insert rear, remove front or
// remove rear.
// Result: rsp_strobe high for one cycle with rsp_data (removed_value, status,
// count_after). Exactly one result per request; the receiver cannot stall,
// so each result must be taken in the cycle it is shown.
// Storage is a row of cells holding the elements in order, front in cell 0.
// For inserts and front removals the result appears the cycle after the
// transfer and busy stays low, so one request per cycle.
// A rear removal sends the tail element forward through the cells one cell
// per cycle; its result is registered once the element reaches cell 0, and
// busy is high until the result appears.
// A refused request (remove from empty, insert into full) answers the cycle
// after the transfer and changes nothing.
// Reset clears the element count and all cell valid flags: the queue is empty
// and ready on the first cycle after reset.
`default_nettype none
module double_ended_queue #(
   parameter int DEPTH = deq_pkg::DepthDef
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  deq_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_strobe,
   output deq_pkg::rsp_type rsp_data
);

   localparam int CntW    = $clog2(DEPTH + 1);
   localparam int RspCntW = deq_pkg::CountW;

   deq_pkg::ctl_state_type state_ff, state_in;
   logic [CntW-1:0]        count_ff, count_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   deq_pkg::rsp_type       rsp_ff, rsp_in;
   deq_pkg::cell_cmd_type  cmd;

   deq_pkg::cell_link_type link       [DEPTH];
   deq_pkg::cell_link_type left_link  [DEPTH];
   deq_pkg::cell_link_type right_link [DEPTH];
   logic [DEPTH-1:0]       valid_vec;
   logic [DEPTH-1:0]       carry_vec;

   logic full;
   logic empty;
   logic accept;
   logic rear_pop_start;

   assign full   = (count_ff == CntW'(DEPTH));
   assign empty  = (count_ff == '0);
   assign accept = start && !busy;
   assign rear_pop_start = accept && !empty && (req_data.func == deq_pkg::FUNC_REM_REAR);

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            assign left_link[gi].valid      = 1'b1;
            assign left_link[gi].carry      = 1'b0;
            assign left_link[gi].data       = req_data.value;
            assign left_link[gi].carry_data = '0;
         end else begin : g_mid
            assign left_link[gi] = link[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_tail
            assign right_link[gi] = '0;
         end else begin : g_body
            assign right_link[gi] = link[gi+1];
         end

         deq_cell u_cell (
            .clock (clock),
            .reset (reset),
            .cmd   (cmd),
            .value (req_data.value),
            .left  (left_link[gi]),
            .right (right_link[gi]),
            .link  (link[gi])
         );

         assign valid_vec[gi] = link[gi].valid;
         assign carry_vec[gi] = link[gi].carry;
      end
   endgenerate

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      cmd           = deq_pkg::CMD_HOLD;
      busy          = (state_ff != deq_pkg::ST_IDLE);
      case (state_ff)
         deq_pkg::ST_IDLE: begin
            if (start) begin
               rsp_in.removed_value = '0;
               rsp_in.status        = deq_pkg::STATUS_OK;
               rsp_strobe_in        = 1'b1;
               case (req_data.func)
                  deq_pkg::FUNC_INS_FRONT: begin
                     if (full) begin
                        rsp_in.status = deq_pkg::STATUS_FULL;
                     end else begin
                        cmd      = deq_pkg::CMD_SHIFT_R;
                        count_in = count_ff + CntW'(1);
                     end
                  end
                  deq_pkg::FUNC_INS_REAR: begin
                     if (full) begin
                        rsp_in.status = deq_pkg::STATUS_FULL;
                     end else begin
                        cmd      = deq_pkg::CMD_PUSH_REAR;
                        count_in = count_ff + CntW'(1);
                     end
                  end
                  deq_pkg::FUNC_REM_FRONT: begin
                     if (empty) begin
                        rsp_in.status = deq_pkg::STATUS_EMPTY;
                     end else begin
                        cmd                  = deq_pkg::CMD_SHIFT_L;
                        count_in             = count_ff - CntW'(1);
                        rsp_in.removed_value = link[0].data;
                     end
                  end
                  deq_pkg::FUNC_REM_REAR: begin
                     if (empty) begin
                        rsp_in.status = deq_pkg::STATUS_EMPTY;
                     end else begin
                        cmd           = deq_pkg::CMD_POP_REAR;
                        count_in      = count_ff - CntW'(1);
                        rsp_strobe_in = 1'b0;
                        state_in      = deq_pkg::ST_DRAIN;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_in.count_after = RspCntW'(count_in);
            end
         end
         deq_pkg::ST_DRAIN: begin
            if (link[0].carry) begin
               rsp_in.removed_value = link[0].carry_data;
               rsp_strobe_in        = 1'b1;
               state_in             = deq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = deq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= deq_pkg::ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`include "double_ended_queue_assert.svh"

   `DEQ_ASSERT_NOW(a_one_token, clock, reset, 1'b1, $onehot0(carry_vec))
   `DEQ_ASSERT_NOW(a_count_match, clock, reset, 1'b1, $countones(valid_vec) == count_ff)
   `DEQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CntW'(DEPTH))
   `DEQ_ASSERT_NEXT(a_drain_busy, clock, reset, rear_pop_start, busy && !rsp_strobe)

endmodule
`default_nettype wire

/* tb/double_ended_queue_checker.sv */
`timescale 1ns / 1ps

module double_ended_queue_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  deq_pkg::req_type req_data,
   input  logic             rsp_strobe,
   input  deq_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               outstanding
);

   localparam int DataW  = deq_pkg::DataWidth;
   localparam int Depth  = deq_pkg::DepthDef;
   localparam int CountW = deq_pkg::CountW;

   logic signed [DataW-1:0] deque_store [Depth];
   int deque_front;
   int deque_count;

   deq_pkg::rsp_type pending_answers [$];
   deq_pkg::rsp_type oldest_answer;
   deq_pkg::rsp_type fresh_answer;

   initial begin
      fail_count  = 0;
      outstanding = 0;
      deque_front = 0;
      deque_count = 0;
   end

   task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                  input logic [DataW-1:0] want);
      $display("%0t ns: %s: got %h, expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   // Applies one request to the shadow deque and returns its answer.
   task automatic apply_to_deque(input deq_pkg::req_type req,
                                 output deq_pkg::rsp_type answer);
      int pos;
      answer        = '0;
      answer.status = deq_pkg::STATUS_OK;
      case (req.func)
         deq_pkg::FUNC_INS_FRONT: begin
            if (deque_count >= Depth) begin
               answer.status = deq_pkg::STATUS_FULL;
            end else begin
               deque_front = (deque_front + Depth - 1) % Depth;
               deque_store[deque_front] = req.value;
               deque_count++;
            end
         end
         deq_pkg::FUNC_INS_REAR: begin
            if (deque_count >= Depth) begin
               answer.status = deq_pkg::STATUS_FULL;
            end else begin
               pos = (deque_front + deque_count) % Depth;
               deque_store[pos] = req.value;
               deque_count++;
            end
         end
         deq_pkg::FUNC_REM_FRONT: begin
            if (deque_count == 0) begin
               answer.status = deq_pkg::STATUS_EMPTY;
            end else begin
               answer.removed_value = deque_store[deque_front];
               deque_front = (deque_front + 1) % Depth;
               deque_count--;
            end
         end
         deq_pkg::FUNC_REM_REAR: begin
            if (deque_count == 0) begin
               answer.status = deq_pkg::STATUS_EMPTY;
            end else begin
               pos = (deque_front + deque_count - 1) % Depth;
               answer.removed_value = deque_store[pos];
               deque_count--;
            end
         end
         default: ;
      endcase
      answer.count_after = CountW'(deque_count);
   endtask

   // Result first: a transfer's own result cannot arrive on the same edge.
   always @(posedge clock) begin
      if (reset) begin
         deque_front = 0;
         deque_count = 0;
         pending_answers.delete();
      end else begin
         if (rsp_strobe) begin
            if (pending_answers.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_data.removed_value, '0);
            end else begin
               oldest_answer = pending_answers.pop_front();
               if (rsp_data.removed_value !== oldest_answer.removed_value)
                  report_mismatch("removed_value", rsp_data.removed_value,
                                  oldest_answer.removed_value);
               if (rsp_data.status !== oldest_answer.status)
                  report_mismatch("status", DataW'(rsp_data.status),
                                  DataW'(oldest_answer.status));
               if (rsp_data.count_after !== oldest_answer.count_after)
                  report_mismatch("count_after", DataW'(rsp_data.count_after),
                                  DataW'(oldest_answer.count_after));
            end
         end
         if (start && !busy) begin
            apply_to_deque(req_data, fresh_answer);
            pending_answers.push_back(fresh_answer);
         end
      end
      outstanding <= pending_answers.size();
   end

endmodule

/* tb/double_ended_queue_tb.sv */
`timescale 1ns / 1ps

module double_ended_queue_tb;

   localparam int DataW = deq_pkg::DataWidth;
   localparam int FuncW = deq_pkg::FuncW;
   localparam int Depth = deq_pkg::DepthDef;
   localparam logic signed [DataW-1:0] MOST_NEG = {1'b1, {(DataW-1){1'b0}}};
   localparam logic signed [DataW-1:0] MOST_POS = {1'b0, {(DataW-1){1'b1}}};
   localparam int RANDOM_PER_PHASE = 275;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   deq_pkg::req_type req_data = '0;
   logic             busy;
   logic             rsp_strobe;
   deq_pkg::rsp_type rsp_data;

   int fail_count;
   int outstanding;
   int idle_pct = 0;

   logic signed [DataW-1:0] extreme_vals [4] = '{MOST_NEG, MOST_POS, '0, '1};
   int phase_idle [4] = '{0, 83, 33, 0};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   double_ended_queue dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   double_ended_queue_checker deque_watch (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   function automatic logic signed [DataW-1:0] pick_value();
      if ($urandom_range(7) == 0) return extreme_vals[$urandom_range(3)];
      return $urandom();
   endfunction

   // Returns at the edge that completed the transfer.
   task automatic send_request(input logic [FuncW-1:0] func,
                               input logic signed [DataW-1:0] value);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start          <= 1'b0;
         req_data.func  <= FuncW'($urandom());
         req_data.value <= $urandom();
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start          <= 1'b1;
      req_data.func  <= func;
      req_data.value <= value;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_until_drained();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      #(2_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int  fill_pct;
      int  stretch;
      logic is_insert;
      logic [FuncW-1:0] func;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty queue, sole element taken from either end, fill, full, wrap
      send_request(deq_pkg::FUNC_REM_FRONT, pick_value());
      send_request(deq_pkg::FUNC_REM_REAR, pick_value());
      send_request(deq_pkg::FUNC_INS_FRONT, MOST_NEG);
      send_request(deq_pkg::FUNC_REM_REAR, pick_value());
      send_request(deq_pkg::FUNC_INS_REAR, MOST_POS);
      send_request(deq_pkg::FUNC_REM_FRONT, pick_value());
      for (int i = 0; i < Depth; i++)
         send_request(i[0] ? deq_pkg::FUNC_INS_REAR : deq_pkg::FUNC_INS_FRONT,
                      (i < 4) ? extreme_vals[i] : DataW'($urandom()));
      send_request(deq_pkg::FUNC_INS_FRONT, pick_value());
      send_request(deq_pkg::FUNC_INS_REAR, pick_value());
      send_request(deq_pkg::FUNC_REM_REAR, pick_value());
      send_request(deq_pkg::FUNC_REM_FRONT, pick_value());
      wait_until_drained();

      // biased walks drive the count between empty and full
      fill_pct = 70;
      stretch  = 0;
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = phase_idle[phase];
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (stretch == 0) begin
               stretch  = $urandom_range(20, 48);
               fill_pct = ($urandom_range(9) == 0) ? 50 : ((fill_pct > 50) ? 25 : 75);
            end
            stretch--;
            is_insert = ($urandom_range(99) < fill_pct);
            if (is_insert)
               func = $urandom_range(1) ? deq_pkg::FUNC_INS_REAR : deq_pkg::FUNC_INS_FRONT;
            else
               func = $urandom_range(1) ? deq_pkg::FUNC_REM_REAR : deq_pkg::FUNC_REM_FRONT;
            send_request(func, pick_value());
            if (phase == 2 && n == RANDOM_PER_PHASE / 2) wait_until_drained();
         end
      end

      wait_until_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
